[design/mcpid_pkg.sv]
// ----------------------------------------------------------------------------
// mcpid_pkg
// Shared types, constants and arithmetic helpers for the multichannel PID
// controller: configuration record, queue word, and the scaling functions.
// ----------------------------------------------------------------------------
package mcpid_pkg;

    // Datapath widths
    localparam int DATA_W      = 16;               // measurement, setpoint, limits
    localparam int GAIN_W      = 15;               // gain registers (unsigned)
    localparam int KG_W        = GAIN_W + 1;       // signed gain after direction
    localparam int ERR_W       = DATA_W + 1;       // difference of two samples
    localparam int PROD_W      = KG_W + ERR_W;     // gain times difference
    localparam int SCALE_SHIFT = 8;
    localparam int SCALE       = 1 << SCALE_SHIFT; // fixed-point scale
    localparam int TERM_W      = PROD_W - SCALE_SHIFT;
    localparam int SUM_W       = TERM_W + 2;       // three terms summed
    localparam int UNS_W       = DATA_W - SCALE_SHIFT;
    localparam int REG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;

    // Input function codes
    typedef enum logic
    {
        FUNC_COMPUTE = 1'b0,
        FUNC_INIT    = 1'b1
    } func_t;

    // Configuration register map
    typedef enum logic [REG_IDX_W-1:0]
    {
        REG_PROP_GAIN   = 3'd0,
        REG_INT_GAIN    = 3'd1,
        REG_DERIV_GAIN  = 3'd2,
        REG_REVERSE_DIR = 3'd3,
        REG_OUT_MIN     = 3'd4,
        REG_OUT_MAX     = 3'd5,
        REG_AUTO_MODE   = 3'd6
    } reg_index_t;

    // Work class decided by the front end
    typedef enum logic [1:0]
    {
        OP_COMPUTE = 2'd0,   // automatic control step
        OP_INIT    = 2'd1,   // bumpless initialise
        OP_HOLD    = 2'd2,   // manual: report held output
        OP_NONE    = 2'd3    // channel not present
    } op_t;

    typedef struct packed
    {
        logic [GAIN_W-1:0]        prop_gain;
        logic [GAIN_W-1:0]        int_gain;
        logic [GAIN_W-1:0]        deriv_gain;
        logic                     reverse_direction;
        logic signed [DATA_W-1:0] out_min;
        logic signed [DATA_W-1:0] out_max;
        logic                     auto_mode;
    } cfg_t;

    // Word passed from front to back through the queue
    typedef struct packed
    {
        op_t                      op;
        logic                     channel;
        logic signed [DATA_W-1:0] meas;
        logic signed [KG_W-1:0]   kd;
        logic signed [TERM_W-1:0] p_term;
        logic signed [TERM_W-1:0] i_term;
    } q_word_t;

    // Product divided by SCALE, truncating toward zero
    function automatic logic signed [TERM_W-1:0] scale_div(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] adj;
        if (p[PROD_W-1])
            adj = p + PROD_W'(SCALE - 1);
        else
            adj = p;
        return TERM_W'(adj >>> SCALE_SHIFT);
    endfunction

    // Output value divided by SCALE, truncating toward zero
    function automatic logic signed [UNS_W-1:0] unscale(input logic signed [DATA_W-1:0] r);
        logic signed [DATA_W-1:0] adj;
        if (r[DATA_W-1])
            adj = r + DATA_W'(SCALE - 1);
        else
            adj = r;
        return UNS_W'(adj >>> SCALE_SHIFT);
    endfunction

    // Upper limit tested first, then lower
    function automatic logic signed [DATA_W-1:0] clamp_out(
        input logic signed [SUM_W-1:0]  v,
        input logic signed [DATA_W-1:0] lo,
        input logic signed [DATA_W-1:0] hi
    );
        logic signed [DATA_W-1:0] r;
        priority if (v > SUM_W'(hi))
            r = hi;
        else if (v < SUM_W'(lo))
            r = lo;
        else
            r = DATA_W'(v);
        return r;
    endfunction

endpackage

[design/mcpid_front.sv]
// ----------------------------------------------------------------------------
// mcpid_front
// Accepts input words, classifies them and forms the proportional and
// integral terms, which need no channel state. One register stage.
// ----------------------------------------------------------------------------
module mcpid_front
    import mcpid_pkg::*;
#(
    parameter int CHANNELS = 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     func,
    input  logic                     channel,
    input  logic signed [DATA_W-1:0] measurement,
    input  logic signed [DATA_W-1:0] setpoint,
    output logic                     q_valid,
    input  logic                     q_ready,
    output q_word_t                  q_word
);

    logic                     fr_valid_reg;
    logic                     fr_valid_next;
    q_word_t                  fr_word_reg;
    q_word_t                  fr_word_next;
    logic                     accept;
    logic                     in_range;
    logic signed [KG_W-1:0]   kp;
    logic signed [KG_W-1:0]   ki;
    logic signed [KG_W-1:0]   kd;
    logic signed [ERR_W-1:0]  err;
    logic signed [PROD_W-1:0] p_prod;
    logic signed [PROD_W-1:0] i_prod;

    // Stage is free when empty or draining into the queue
    assign in_ready = !fr_valid_reg || q_ready;
    assign accept   = in_valid && in_ready;
    assign in_range = 32'(channel) < CHANNELS;

    // Gains with direction applied
    always_comb
    begin
        kp = $signed({1'b0, cfg.prop_gain});
        ki = $signed({1'b0, cfg.int_gain});
        kd = $signed({1'b0, cfg.deriv_gain});
        if (cfg.reverse_direction)
        begin
            kp = -kp;
            ki = -ki;
            kd = -kd;
        end
    end

    // Error and the two state-free products
    assign err    = ERR_W'(setpoint) - ERR_W'(measurement);
    assign p_prod = PROD_W'(kp) * PROD_W'(err);
    assign i_prod = PROD_W'(ki) * PROD_W'(err);

    // Classification and word assembly
    always_comb
    begin
        fr_word_next.channel = channel;
        fr_word_next.meas    = measurement;
        fr_word_next.kd      = kd;
        fr_word_next.p_term  = scale_div(p_prod);
        fr_word_next.i_term  = scale_div(i_prod);
        priority if (!in_range)
            fr_word_next.op = OP_NONE;
        else if (func_t'(func) == FUNC_INIT)
            fr_word_next.op = OP_INIT;
        else if (!cfg.auto_mode)
            fr_word_next.op = OP_HOLD;
        else
            fr_word_next.op = OP_COMPUTE;
    end

    always_comb
    begin
        if (accept)
            fr_valid_next = 1'b1;
        else if (q_ready)
            fr_valid_next = 1'b0;
        else
            fr_valid_next = fr_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fr_valid_reg <= 1'b0;
        else
            fr_valid_reg <= fr_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            fr_word_reg <= fr_word_next;
    end

    assign q_valid = fr_valid_reg;
    assign q_word  = fr_word_reg;

    // A word refused by the queue must hold
    a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fr_valid_reg && !q_ready |=> fr_valid_reg && fr_word_reg == $past(fr_word_reg))
        else $error("front word changed while stalled");

endmodule

[design/mcpid_queue.sv]
// ----------------------------------------------------------------------------
// mcpid_queue
// Short queue between front and back so that each side can stall on its
// own. Simultaneous push and pop are allowed.
// ----------------------------------------------------------------------------
module mcpid_queue
    import mcpid_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  q_word_t push_word,
    output logic    pop_valid,
    input  logic    pop_ready,
    output q_word_t pop_word
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_word_t            entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               push;
    logic               pop;

    assign push_ready = count_reg != CNT_W'(QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_word   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_word;
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue fill count out of range");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

[design/mcpid_back.sv]
// ----------------------------------------------------------------------------
// mcpid_back
// Executes queued words against per-channel state: derivative term,
// integral update and output clamp, in one read-modify-write per word.
// Holds the result in an output register.
// ----------------------------------------------------------------------------
module mcpid_back
    import mcpid_pkg::*;
#(
    parameter int CHANNELS = 2
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     q_valid,
    output logic                     q_ready,
    input  q_word_t                  q_word,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     out_channel,
    output logic signed [DATA_W-1:0] control_output,
    output logic signed [UNS_W-1:0]  unscaled_output,
    output logic                     updated
);

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Per-channel state
    logic signed [DATA_W-1:0] integ_reg [CHANNELS];
    logic signed [DATA_W-1:0] prev_reg  [CHANNELS];
    logic signed [DATA_W-1:0] held_reg  [CHANNELS];

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_channel_reg;
    logic signed [DATA_W-1:0] ctrl_reg;
    logic signed [UNS_W-1:0]  uns_reg;
    logic                     upd_reg;

    logic                     pop;
    logic [CH_IDX_W-1:0]      idx;
    logic signed [DATA_W-1:0] integ_cur;
    logic signed [DATA_W-1:0] prev_cur;
    logic signed [DATA_W-1:0] held_cur;
    logic signed [ERR_W-1:0]  d_in;
    logic signed [PROD_W-1:0] d_prod;
    logic signed [TERM_W-1:0] d_term;
    logic signed [DATA_W-1:0] integ_step;
    logic signed [DATA_W-1:0] pid_out;
    logic signed [DATA_W-1:0] result;
    logic                     upd;
    logic                     integ_we;
    logic                     prev_we;
    logic                     held_we;
    logic signed [DATA_W-1:0] integ_next;

    assign q_ready = !out_valid_reg || out_ready;
    assign pop     = q_valid && q_ready;
    assign idx     = CH_IDX_W'(q_word.channel);

    assign integ_cur = integ_reg[idx];
    assign prev_cur  = prev_reg[idx];
    assign held_cur  = held_reg[idx];

    // Derivative on measurement
    assign d_in   = ERR_W'(q_word.meas) - ERR_W'(prev_cur);
    assign d_prod = PROD_W'(q_word.kd) * PROD_W'(d_in);
    assign d_term = scale_div(d_prod);

    // Integral step and output, both clamped to the limits
    assign integ_step = clamp_out(SUM_W'(integ_cur) + SUM_W'(q_word.i_term),
                                  cfg.out_min, cfg.out_max);
    assign pid_out    = clamp_out(SUM_W'(q_word.p_term) + SUM_W'(integ_step)
                                  - SUM_W'(d_term), cfg.out_min, cfg.out_max);

    // Result selection and state write enables
    always_comb
    begin
        result     = held_cur;
        upd        = 1'b0;
        integ_we   = 1'b0;
        prev_we    = 1'b0;
        held_we    = 1'b0;
        integ_next = integ_step;
        unique case (q_word.op)
            OP_COMPUTE:
            begin
                result   = pid_out;
                upd      = 1'b1;
                integ_we = 1'b1;
                prev_we  = 1'b1;
                held_we  = 1'b1;
            end
            OP_INIT:
            begin
                integ_next = clamp_out(SUM_W'(held_cur), cfg.out_min, cfg.out_max);
                integ_we   = 1'b1;
                prev_we    = 1'b1;
            end
            OP_HOLD:
            begin
                result = held_cur;
            end
            OP_NONE:
            begin
                result = '0;
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // Channel state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                integ_reg[i] <= '0;
                prev_reg[i]  <= '0;
                held_reg[i]  <= '0;
            end
        end
        else if (pop)
        begin
            if (integ_we)
                integ_reg[idx] <= integ_next;
            if (prev_we)
                prev_reg[idx] <= q_word.meas;
            if (held_we)
                held_reg[idx] <= pid_out;
        end
    end

    // Output register
    always_comb
    begin
        if (pop)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_channel_reg <= q_word.channel;
            ctrl_reg        <= result;
            uns_reg         <= unscale(result);
            upd_reg         <= upd;
        end
    end

    assign out_valid       = out_valid_reg;
    assign out_channel     = out_channel_reg;
    assign control_output  = ctrl_reg;
    assign unscaled_output = uns_reg;
    assign updated         = upd_reg;

    // A computed output becomes the channel's held output
    a_held_follows: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_word.op == OP_COMPUTE |=> held_reg[$past(idx)] == ctrl_reg)
        else $error("held output does not match computed word");

    // Only a compute step reports a fresh value
    a_upd_compute: assert property (@(posedge clk) disable iff (!rst_n)
        pop && q_word.op != OP_COMPUTE |=> !upd_reg)
        else $error("updated flag set for a non-compute word");

endmodule

[design/multichannel_pid_controller_top.sv]
// ----------------------------------------------------------------------------
// multichannel_pid_controller_top
// Each taken word passes the front register, the queue and the output register.
// Throughput: one word per cycle without stalls, even on the same channel, since
// the back end reads, updates and writes a channel's state in the same cycle.
// Reset clears all channel state to zero and the registers to their defaults.
// Front end, two-entry queue and output register let each side stall alone.
// ----------------------------------------------------------------------------
module multichannel_pid_controller_top
    import mcpid_pkg::*;
#(
    parameter int CHANNELS = 2
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration write port
    input  logic                        cfg_wr_en,
    input  logic [REG_IDX_W-1:0]        cfg_index,
    input  logic [DATA_W-1:0]           cfg_data,
    // input channel
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic                        channel,
    input  logic signed [DATA_W-1:0]    measurement,
    input  logic signed [DATA_W-1:0]    setpoint,
    // result channel
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_channel,
    output logic signed [DATA_W-1:0]    control_output,
    output logic signed [UNS_W-1:0]     unscaled_output,
    output logic                        updated
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    fq_valid;
    logic    fq_ready;
    q_word_t fq_word;
    logic    qb_valid;
    logic    qb_ready;
    q_word_t qb_word;

    // Register file write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_PROP_GAIN:   cfg_next.prop_gain         = cfg_data[GAIN_W-1:0];
                REG_INT_GAIN:    cfg_next.int_gain          = cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:  cfg_next.deriv_gain        = cfg_data[GAIN_W-1:0];
                REG_REVERSE_DIR: cfg_next.reverse_direction = cfg_data[0];
                REG_OUT_MIN:     cfg_next.out_min           = $signed(cfg_data);
                REG_OUT_MAX:     cfg_next.out_max           = $signed(cfg_data);
                REG_AUTO_MODE:   cfg_next.auto_mode         = cfg_data[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain         <= '0;
            cfg_reg.int_gain          <= '0;
            cfg_reg.deriv_gain        <= '0;
            cfg_reg.reverse_direction <= 1'b0;
            cfg_reg.out_min           <= {1'b1, {(DATA_W-1){1'b0}}};
            cfg_reg.out_max           <= {1'b0, {(DATA_W-1){1'b1}}};
            cfg_reg.auto_mode         <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mcpid_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .channel     (channel),
        .measurement (measurement),
        .setpoint    (setpoint),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_word      (fq_word)
    );

    mcpid_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_word  (fq_word),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_word   (qb_word)
    );

    mcpid_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .q_valid         (qb_valid),
        .q_ready         (qb_ready),
        .q_word          (qb_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_channel     (out_channel),
        .control_output  (control_output),
        .unscaled_output (unscaled_output),
        .updated         (updated)
    );

endmodule

[verif/multichannel_pid_controller_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multichannel_pid_controller_top_tb
// Drives sample words into the two-channel PID controller and checks every
// result word against a cycle-free model of the control law that the bench
// keeps alongside. A short table of directed words comes first, followed by
// phases of random words under random gains, limits, direction and mode.
// Both handshakes idle at random, and in one phase the result side holds off
// long enough to fill the block and back-pressure the input.
// ----------------------------------------------------------------------------
module multichannel_pid_controller_top_tb
    import mcpid_pkg::*;
();

    localparam int     CHANNELS    = 2;
    localparam longint SCALE_L     = SCALE;
    localparam int     SETTLE      = 4;
    localparam int     HOLD_CYCLES = 120;
    localparam int     RAND_PHASES = 12;
    localparam int     DIR_ROWS    = 20;
    localparam int     CYCLE_LIMIT = 400_000;
    localparam int     MAX_REPORTS = 10;

    // One result word as seen on the output ports
    typedef struct packed
    {
        logic                     ch;
        logic signed [DATA_W-1:0] ctrl;
        logic signed [UNS_W-1:0]  uns;
        logic                     upd;
    } pid_word_t;

    // One row of directed stimulus; want is used only when typed is set
    typedef struct packed
    {
        logic [2:0]               sel;
        func_t                    op;
        logic                     ch;
        logic signed [DATA_W-1:0] meas;
        logic signed [DATA_W-1:0] target;
        logic                     typed;
        pid_word_t                want;
    } dir_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [REG_IDX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]        cfg_data;
    logic                     in_valid;
    logic                     in_ready;
    logic                     func;
    logic                     channel;
    logic signed [DATA_W-1:0] measurement;
    logic signed [DATA_W-1:0] setpoint;
    logic                     out_valid;
    logic                     out_ready;
    logic                     out_channel;
    logic signed [DATA_W-1:0] control_output;
    logic signed [UNS_W-1:0]  unscaled_output;
    logic                     updated;

    multichannel_pid_controller_top #(.CHANNELS(CHANNELS)) dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .channel         (channel),
        .measurement     (measurement),
        .setpoint        (setpoint),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .out_channel     (out_channel),
        .control_output  (control_output),
        .unscaled_output (unscaled_output),
        .updated         (updated)
    );

    // Register settings used by the directed table
    cfg_t cfg_table [5] = '{
        '{15'd0,    15'd0,    15'd0,    1'b0, 16'sh8000,  16'sh7fff, 1'b0},  // reset values
        '{15'h7fff, 15'd0,    15'd0,    1'b0, 16'sh8000,  16'sh7fff, 1'b1},  // full P gain
        '{15'd300,  15'h7fff, 15'h7fff, 1'b1, -16'sd1000, 16'sd1000, 1'b1},  // reverse, tight
        '{15'd256,  15'd100,  15'd50,   1'b0, 16'sd500,   -16'sd500, 1'b1},  // crossed limits
        '{15'd1000, 15'd1000, 15'd1000, 1'b0, 16'sh8000,  16'sh7fff, 1'b0}   // manual again
    };

    // Directed words; 16'sh8000 / 8'sh80 are the most negative values
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{3'd0, FUNC_COMPUTE, 1'b0, 16'sh8000, 16'sh7fff, 1'b1, '{1'b0, 16'sd0, 8'sd0, 1'b0}},
        '{3'd0, FUNC_COMPUTE, 1'b1, 16'sh7fff, 16'sh8000, 1'b1, '{1'b1, 16'sd0, 8'sd0, 1'b0}},
        '{3'd0, FUNC_INIT,    1'b0, 16'sd0,    16'sd0,    1'b1, '{1'b0, 16'sd0, 8'sd0, 1'b0}},
        '{3'd0, FUNC_INIT,    1'b1, 16'sd0,    16'sd0,    1'b1, '{1'b1, 16'sd0, 8'sd0, 1'b0}},
        '{3'd1, FUNC_COMPUTE, 1'b0, 16'sh8000, 16'sh7fff, 1'b1,
          '{1'b0, 16'sh7fff, 8'sh7f, 1'b1}},
        '{3'd1, FUNC_COMPUTE, 1'b1, 16'sh7fff, 16'sh8000, 1'b1,
          '{1'b1, 16'sh8000, 8'sh80, 1'b1}},
        '{3'd1, FUNC_COMPUTE, 1'b0, 16'sd100,  16'sd100,  1'b0, '0},
        '{3'd1, FUNC_INIT,    1'b1, 16'sd5,    16'sd0,    1'b0, '0},
        '{3'd1, FUNC_COMPUTE, 1'b1, 16'sd5,    16'sd5,    1'b0, '0},
        '{3'd2, FUNC_INIT,    1'b0, 16'sd0,    16'sd0,    1'b0, '0},
        '{3'd2, FUNC_COMPUTE, 1'b0, 16'sd0,    16'sd0,    1'b0, '0},
        '{3'd2, FUNC_COMPUTE, 1'b0, 16'sh8000, 16'sh7fff, 1'b0, '0},
        '{3'd2, FUNC_COMPUTE, 1'b1, 16'sh7fff, 16'sh7fff, 1'b0, '0},
        '{3'd2, FUNC_COMPUTE, 1'b0, 16'sd10,   16'sd20,   1'b0, '0},
        '{3'd3, FUNC_COMPUTE, 1'b0, 16'sd0,    16'sd300,  1'b0, '0},
        '{3'd3, FUNC_COMPUTE, 1'b1, 16'sd0,    -16'sd300, 1'b0, '0},
        '{3'd3, FUNC_COMPUTE, 1'b0, 16'sd0,    16'sd0,    1'b0, '0},
        '{3'd4, FUNC_COMPUTE, 1'b0, 16'sd1234, -16'sd1234, 1'b0, '0},
        '{3'd4, FUNC_INIT,    1'b1, -16'sd77,  16'sd0,    1'b0, '0},
        '{3'd4, FUNC_COMPUTE, 1'b1, 16'sd0,    16'sd0,    1'b0, '0}
    };

    // Control law state and registers as the bench sees them
    cfg_t      model_cfg;
    longint    integ_acc [CHANNELS];
    longint    last_meas [CHANNELS];
    longint    held_out  [CHANNELS];

    pid_word_t pending_outputs [$];
    int        mismatch_count;
    int        cycle_count = 0;
    bit        calm;
    bit        long_hold;
    logic signed [DATA_W-1:0] target [CHANNELS];

    // Clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Clamp to the current limits: upper first, then lower
    function automatic longint limit(input longint v);
        longint lo;
        longint hi;
        lo = $signed(model_cfg.out_min);
        hi = $signed(model_cfg.out_max);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // One sample through the control law; updates channel state
    function automatic pid_word_t pid_step(
        input func_t                    op,
        input logic                     ch,
        input logic signed [DATA_W-1:0] meas_v,
        input logic signed [DATA_W-1:0] sp_v
    );
        pid_word_t w;
        longint    kp;
        longint    ki;
        longint    kd;
        longint    m;
        longint    s;
        longint    err;
        longint    dm;
        longint    integ;
        longint    res;
        m     = meas_v;
        s     = sp_v;
        res   = held_out[ch];
        w.upd = 1'b0;
        if (op == FUNC_INIT)
        begin
            // bumpless start from the held output
            integ_acc[ch] = limit(held_out[ch]);
            last_meas[ch] = m;
        end
        else if (model_cfg.auto_mode)
        begin
            kp = longint'(model_cfg.prop_gain);
            ki = longint'(model_cfg.int_gain);
            kd = longint'(model_cfg.deriv_gain);
            if (model_cfg.reverse_direction)
            begin
                kp = -kp;
                ki = -ki;
                kd = -kd;
            end
            err           = s - m;
            integ         = limit(integ_acc[ch] + (ki * err) / SCALE_L);
            integ_acc[ch] = integ;
            // derivative acts on the measurement, not the error
            dm            = m - last_meas[ch];
            res           = limit((kp * err) / SCALE_L + integ - (kd * dm) / SCALE_L);
            held_out[ch]  = res;
            last_meas[ch] = m;
            w.upd         = 1'b1;
        end
        w.ch   = ch;
        w.ctrl = DATA_W'(res);
        w.uns  = UNS_W'(res / SCALE_L);
        return w;
    endfunction

    // Idle length for either side: mostly none, some short, a few long
    function automatic int unsigned idle_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        if (r < 6)
            return GAIN_W'($urandom_range(0, 512));
        return GAIN_W'($urandom);
    endfunction

    function automatic cfg_t random_settings();
        cfg_t                     c;
        logic signed [DATA_W-1:0] a;
        logic signed [DATA_W-1:0] b;
        int unsigned              r;
        c.prop_gain         = pick_gain();
        c.int_gain          = pick_gain();
        c.deriv_gain        = pick_gain();
        c.reverse_direction = 1'($urandom_range(0, 1));
        c.auto_mode         = ($urandom_range(0, 4) != 0);
        a = DATA_W'($urandom);
        b = DATA_W'($urandom);
        r = $urandom_range(0, 7);
        if (r == 0)
        begin
            c.out_min = 16'sh8000;
            c.out_max = 16'sh7fff;
        end
        else if (r == 1)
        begin
            // crossed limits
            c.out_min = (a > b) ? a : b;
            c.out_max = (a > b) ? b : a;
        end
        else
        begin
            c.out_min = (a < b) ? a : b;
            c.out_max = (a < b) ? b : a;
        end
        return c;
    endfunction

    // Register write; the bench's copy follows at once since the block is idle
    task automatic write_reg(input reg_index_t idx, input logic [DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_PROP_GAIN:   model_cfg.prop_gain         = val[GAIN_W-1:0];
            REG_INT_GAIN:    model_cfg.int_gain          = val[GAIN_W-1:0];
            REG_DERIV_GAIN:  model_cfg.deriv_gain        = val[GAIN_W-1:0];
            REG_REVERSE_DIR: model_cfg.reverse_direction = val[0];
            REG_OUT_MIN:     model_cfg.out_min           = val;
            REG_OUT_MAX:     model_cfg.out_max           = val;
            REG_AUTO_MODE:   model_cfg.auto_mode         = val[0];
            default:         ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input cfg_t s);
        write_reg(REG_PROP_GAIN,   DATA_W'(s.prop_gain));
        write_reg(REG_INT_GAIN,    DATA_W'(s.int_gain));
        write_reg(REG_DERIV_GAIN,  DATA_W'(s.deriv_gain));
        write_reg(REG_REVERSE_DIR, DATA_W'(s.reverse_direction));
        write_reg(REG_OUT_MIN,     s.out_min);
        write_reg(REG_OUT_MAX,     s.out_max);
        write_reg(REG_AUTO_MODE,   DATA_W'(s.auto_mode));
    endtask

    // Offer one sample word, wait for it to be taken, then idle a while
    task automatic drive_word(
        input func_t                    op,
        input logic                     ch,
        input logic signed [DATA_W-1:0] meas_v,
        input logic signed [DATA_W-1:0] sp_v,
        input logic                     use_typed,
        input pid_word_t                typed_want
    );
        pid_word_t   w;
        int unsigned gap;
        in_valid    <= 1'b1;
        func        <= op;
        channel     <= ch;
        measurement <= meas_v;
        setpoint    <= sp_v;
        do
            @(posedge clk);
        while (!in_ready);
        w = pid_step(op, ch, meas_v, sp_v);
        pending_outputs.push_back(use_typed ? typed_want : w);
        gap = idle_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop offering and let every outstanding result drain
    task automatic finish_traffic();
        in_valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_random_sample();
        func_t                    op;
        logic                     ch;
        logic signed [DATA_W-1:0] m;
        logic signed [DATA_W-1:0] sp;
        op = ($urandom_range(0, 11) == 0) ? FUNC_INIT : FUNC_COMPUTE;
        ch = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 19) == 0)
            target[ch] = DATA_W'($urandom);
        // mostly a process settling near its target, sometimes anything at all
        if ($urandom_range(0, 3) == 0)
            sp = DATA_W'($urandom);
        else
            sp = target[ch];
        if ($urandom_range(0, 4) == 0)
            m = DATA_W'($urandom);
        else
            m = sp + DATA_W'($urandom_range(0, 512)) - 16'sd256;
        drive_word(op, ch, m, sp, 1'b0, '0);
    endtask

    function automatic void note_mismatch(input string what, input pid_word_t want,
                                          input pid_word_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
        begin
            $display("%0t: %s: expected ch=%0d out=%0d uns=%0d upd=%0d",
                     $realtime, what, want.ch, want.ctrl, want.uns, want.upd);
            $display("    got ch=%0d out=%0d uns=%0d upd=%0d",
                     got.ch, got.ctrl, got.uns, got.upd);
        end
    endfunction

    // Result checker
    always @(posedge clk)
    begin : result_check
        pid_word_t got;
        pid_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{out_channel, control_output, unscaled_output, updated};
            if (pending_outputs.size() == 0)
                note_mismatch("result word with nothing outstanding", '0, got);
            else
            begin
                want = pending_outputs.pop_front();
                if (got.ch !== want.ch || got.ctrl !== want.ctrl ||
                    got.uns !== want.uns || got.upd !== want.upd)
                    note_mismatch("result word mismatch", want, got);
            end
        end
    end

    // Result side: random ready stretches, plus one long hold on request
    initial
    begin : result_sink
        int unsigned run_len;
        int unsigned stall_len;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            run_len = $urandom_range(1, 24);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall_len = idle_gap();
            if (stall_len != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // Stimulus
    initial
    begin : stimulus
        logic [2:0]  cur_sel;
        logic        was_auto;
        int unsigned phase_items;
        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= REG_PROP_GAIN;
        cfg_data       <= '0;
        in_valid       <= 1'b0;
        func           <= FUNC_COMPUTE;
        channel        <= 1'b0;
        measurement    <= '0;
        setpoint       <= '0;
        mismatch_count = 0;
        calm           = 1'b0;
        long_hold      = 1'b0;
        model_cfg      = cfg_table[0];
        for (int c = 0; c < CHANNELS; c++)
        begin
            integ_acc[c] = 0;
            last_meas[c] = 0;
            held_out[c]  = 0;
            target[c]    = '0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table; the first rows run on the reset settings
        cur_sel = 3'd0;
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (dir_rows[i].sel != cur_sel)
            begin
                finish_traffic();
                cur_sel = dir_rows[i].sel;
                apply_settings(cfg_table[cur_sel]);
            end
            drive_word(dir_rows[i].op, dir_rows[i].ch, dir_rows[i].meas,
                       dir_rows[i].target, dir_rows[i].typed, dir_rows[i].want);
        end

        // Random phases, each under fresh register settings
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            finish_traffic();
            was_auto = model_cfg.auto_mode;
            apply_settings(random_settings());
            calm = (p % 4 == 1);
            if (p == 2)
                long_hold = 1'b1;
            for (int c = 0; c < CHANNELS; c++)
                target[c] = DATA_W'($urandom);
            // usual practice: initialise both loops when entering automatic mode
            if (!was_auto && model_cfg.auto_mode && $urandom_range(0, 4) != 0)
            begin
                drive_word(FUNC_INIT, 1'b0, target[0], target[0], 1'b0, '0);
                drive_word(FUNC_INIT, 1'b1, target[1], target[1], 1'b0, '0);
            end
            phase_items = $urandom_range(80, 108);
            repeat (phase_items) send_random_sample();
        end

        calm = 1'b0;
        finish_traffic();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0 && pending_outputs.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
